>>> sv/rtp_h264_hevc_depacketizer_top_assert.svh
// Assertion macros shared by the depacketizer modules.
// Each module that asserts provides clk and rst_n in scope.
`ifndef RTP_H264_HEVC_DEPACKETIZER_TOP_ASSERT_SVH
`define RTP_H264_HEVC_DEPACKETIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RHD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhd: assertion failed");

// Next-cycle implication.
`define RHD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhd: assertion failed");

`endif

>>> sv/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg
// Types, codes and NAL header helpers for the RTP H.264/HEVC depacketizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rhd_pkg;

    // codec select
    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_HEVC = 1'b1;

    // packet-level NAL types
    localparam logic [4:0] H264_T_STAPA = 5'd24;
    localparam logic [4:0] H264_T_FUA   = 5'd28;
    localparam logic [4:0] H264_T_IDR   = 5'd5;
    localparam logic [4:0] H264_T_SEI   = 5'd6;
    localparam logic [4:0] H264_T_MAX   = 5'd23;
    localparam logic [5:0] HEVC_T_MAX   = 6'd47;
    localparam logic [5:0] HEVC_T_AP    = 6'd48;
    localparam logic [5:0] HEVC_T_FU    = 6'd49;
    localparam logic [5:0] HEVC_T_IRAP_LO = 6'd16;
    localparam logic [5:0] HEVC_T_IRAP_HI = 6'd23;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TYPE     = 2'd1;
    localparam logic [1:0] ERR_SIZE     = 2'd2;
    localparam logic [1:0] ERR_FU_SHORT = 2'd3;

    // frame class
    localparam logic [1:0] FK_B     = 2'd0;
    localparam logic [1:0] FK_OTHER = 2'd1;
    localparam logic [1:0] FK_INTRA = 2'd2;

    // start code 00 00 00 01: its zero byte and its last byte
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_SKIP      = 10'b00_0000_0010,
        PH_SECOND    = 10'b00_0000_0100,
        PH_COPY      = 10'b00_0000_1000,
        PH_SIZE_HI   = 10'b00_0001_0000,
        PH_SIZE_LO   = 10'b00_0010_0000,
        PH_SUB_FIRST = 10'b00_0100_0000,
        PH_SUB_REST  = 10'b00_1000_0000,
        PH_TRAIL     = 10'b01_0000_0000,
        PH_FU_HDR    = 10'b10_0000_0000
    } phase_t;

    // All results caused by one payload byte.
    typedef struct packed {
        logic       sc;      // start code leads the results
        logic [1:0] nb;      // stream bytes after the start code (0..2)
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] err;
        logic [1:0] fclass;
    } rhd_bundle_t;

    function automatic logic [1:0] class_h264(input logic [7:0] hdr, input logic [1:0] fk);
        logic [4:0] t;
        logic [1:0] r;
        t = hdr[4:0];
        r = fk;
        if (t >= 5'd1 && t <= H264_T_MAX) begin
            if (t == H264_T_IDR || t == H264_T_SEI)
                r = FK_INTRA;
            else if (fk == FK_B && hdr[6:5] != 2'd0)
                r = FK_OTHER;
        end
        return r;
    endfunction

    function automatic logic [1:0] class_hevc(input logic [7:0] hdr);
        logic [5:0] t;
        t = hdr[6:1];
        return (t >= HEVC_T_IRAP_LO && t <= HEVC_T_IRAP_HI) ? FK_INTRA : FK_OTHER;
    endfunction

endpackage

`default_nettype wire

>>> sv/rhd_parse.sv
// ----------------------------------------------------------------------------
// rhd_parse
// Input register and payload parser: one byte per cycle while bnd_ready is high, into a result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_parse (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [23:0]          s_axis_tdata,  // data_byte[7:0], bytes_left[23:8]
    input  wire logic [1:0]           s_axis_tuser,  // packet_start[0], frame_start[1]
    output logic                      bnd_valid,
    input  wire logic                 bnd_ready,
    output rhd_pkg::rhd_bundle_t      bnd
);

    `include "rtp_h264_hevc_depacketizer_top_assert.svh"

    logic                 codec_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic [15:0]          in_left_reg;
    logic                 in_ps_reg;
    logic                 in_fs_reg;

    rhd_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]           hdr1_reg, hdr1_next;
    logic [7:0]           hdr2_reg, hdr2_next;
    logic [7:0]           size_hi_reg, size_hi_next;
    logic [15:0]          sub_left_reg, sub_left_next;
    logic [1:0]           fk_reg, fk_next;
    logic                 drop_reg, drop_next;

    logic                 adv;
    logic [15:0]          len;
    logic [15:0]          lenm1;
    logic [15:0]          sz;
    logic [15:0]          left_dec;
    logic [7:0]           r0;
    logic [4:0]           t264;
    logic [5:0]           t265;
    rhd_pkg::phase_t      agg_phase;
    rhd_pkg::rhd_bundle_t bnd_next;

    assign cfg_ready     = 1'b1;
    assign adv           = in_valid_reg && bnd_ready;
    assign s_axis_tready = !in_valid_reg || bnd_ready;
    assign bnd_valid     = adv;
    assign bnd           = bnd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_reg    <= rhd_pkg::CODEC_H264;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                codec_reg <= cfg_data;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_left_reg <= s_axis_tdata[23:8];
            in_ps_reg   <= s_axis_tuser[0];
            in_fs_reg   <= s_axis_tuser[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rhd_pkg::PH_IDLE;
            hdr1_reg     <= 8'd0;
            hdr2_reg     <= 8'd0;
            size_hi_reg  <= 8'd0;
            sub_left_reg <= 16'd0;
            fk_reg       <= rhd_pkg::FK_B;
            drop_reg     <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg    <= phase_next;
            hdr1_reg     <= hdr1_next;
            hdr2_reg     <= hdr2_next;
            size_hi_reg  <= size_hi_next;
            sub_left_reg <= sub_left_next;
            fk_reg       <= fk_next;
            drop_reg     <= drop_next;
        end
    end

    assign len       = (in_left_reg == 16'd0) ? 16'd1 : in_left_reg;
    assign lenm1     = len - 16'd1;
    assign sz        = {size_hi_reg, in_byte_reg};
    assign left_dec  = (sub_left_reg != 16'd0) ? sub_left_reg - 16'd1 : 16'd0;
    assign t264      = in_byte_reg[4:0];
    assign t265      = in_byte_reg[6:1];
    // two bytes or fewer left after this byte cannot hold another non-empty sub-NAL
    assign agg_phase = (lenm1 > 16'd2) ? rhd_pkg::PH_SIZE_HI : rhd_pkg::PH_TRAIL;
    assign r0        = (codec_reg == rhd_pkg::CODEC_H264) ?
                       {hdr1_reg[7:5], in_byte_reg[4:0]} :
                       {hdr1_reg[7], in_byte_reg[5:0], hdr1_reg[0]};

    always_comb
    begin
        phase_next    = phase_reg;
        hdr1_next     = hdr1_reg;
        hdr2_next     = hdr2_reg;
        size_hi_next  = size_hi_reg;
        sub_left_next = sub_left_reg;
        fk_next       = in_fs_reg ? rhd_pkg::FK_B : fk_reg;
        drop_next     = drop_reg;
        bnd_next.sc   = 1'b0;
        bnd_next.nb   = 2'd0;
        bnd_next.b0   = in_byte_reg;
        bnd_next.b1   = hdr2_reg;
        bnd_next.err  = rhd_pkg::ERR_NONE;

        if (in_ps_reg)
        begin
            drop_next  = 1'b0;
            phase_next = rhd_pkg::PH_IDLE;
            hdr1_next  = in_byte_reg;
            if (codec_reg == rhd_pkg::CODEC_H264)
            begin
                if (t264 >= 5'd1 && t264 <= rhd_pkg::H264_T_MAX)
                begin
                    fk_next     = rhd_pkg::class_h264(in_byte_reg, fk_next);
                    bnd_next.sc = 1'b1;
                    bnd_next.nb = 2'd1;
                    phase_next  = rhd_pkg::PH_COPY;
                end
                else if (t264 == rhd_pkg::H264_T_STAPA)
                    phase_next = agg_phase;
                else if (t264 == rhd_pkg::H264_T_FUA && lenm1 > 16'd1)
                    phase_next = rhd_pkg::PH_FU_HDR;
                else
                begin
                    bnd_next.err = (t264 == rhd_pkg::H264_T_FUA) ?
                                   rhd_pkg::ERR_FU_SHORT : rhd_pkg::ERR_TYPE;
                    drop_next    = 1'b1;
                end
            end
            else
            begin
                fk_next = rhd_pkg::class_hevc(in_byte_reg);
                if (t265 <= rhd_pkg::HEVC_T_MAX)
                begin
                    bnd_next.sc = 1'b1;
                    bnd_next.nb = 2'd1;
                    phase_next  = rhd_pkg::PH_COPY;
                end
                else if (t265 == rhd_pkg::HEVC_T_AP)
                    phase_next = rhd_pkg::PH_SKIP;
                else if (t265 == rhd_pkg::HEVC_T_FU && len >= 16'd4)
                    phase_next = rhd_pkg::PH_SECOND;
                else
                begin
                    bnd_next.err = (t265 == rhd_pkg::HEVC_T_FU) ?
                                   rhd_pkg::ERR_FU_SHORT : rhd_pkg::ERR_TYPE;
                    drop_next    = 1'b1;
                end
            end
        end
        else if (!drop_reg)
        begin
            case (phase_reg)
                rhd_pkg::PH_SKIP:
                    phase_next = agg_phase;
                rhd_pkg::PH_SECOND:
                begin
                    hdr2_next  = in_byte_reg;
                    phase_next = rhd_pkg::PH_FU_HDR;
                end
                rhd_pkg::PH_FU_HDR:
                begin
                    // start fragment: rebuild the NAL header
                    if (in_byte_reg[7])
                    begin
                        bnd_next.sc = 1'b1;
                        bnd_next.b0 = r0;
                        if (codec_reg == rhd_pkg::CODEC_H264)
                        begin
                            bnd_next.nb = 2'd1;
                            fk_next     = rhd_pkg::class_h264(r0, fk_next);
                        end
                        else
                        begin
                            bnd_next.nb = 2'd2;
                            fk_next     = rhd_pkg::class_hevc(r0);
                        end
                    end
                    phase_next = rhd_pkg::PH_COPY;
                end
                rhd_pkg::PH_COPY:
                    bnd_next.nb = 2'd1;
                rhd_pkg::PH_SIZE_HI:
                begin
                    size_hi_next = in_byte_reg;
                    phase_next   = rhd_pkg::PH_SIZE_LO;
                end
                rhd_pkg::PH_SIZE_LO:
                begin
                    if (sz > lenm1)
                    begin
                        bnd_next.err = rhd_pkg::ERR_SIZE;
                        drop_next    = 1'b1;
                        phase_next   = rhd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        bnd_next.sc = 1'b1;
                        if (sz == 16'd0)
                            phase_next = agg_phase;
                        else
                        begin
                            sub_left_next = sz;
                            phase_next    = rhd_pkg::PH_SUB_FIRST;
                        end
                    end
                end
                rhd_pkg::PH_SUB_FIRST, rhd_pkg::PH_SUB_REST:
                begin
                    bnd_next.nb = 2'd1;
                    if (phase_reg == rhd_pkg::PH_SUB_FIRST)
                        fk_next = (codec_reg == rhd_pkg::CODEC_H264) ?
                                  rhd_pkg::class_h264(in_byte_reg, fk_next) :
                                  rhd_pkg::class_hevc(in_byte_reg);
                    sub_left_next = left_dec;
                    phase_next    = (left_dec == 16'd0) ? agg_phase : rhd_pkg::PH_SUB_REST;
                end
                default:
                    ;
            endcase
        end

        if (len == 16'd1)
            phase_next = rhd_pkg::PH_IDLE;
        bnd_next.fclass = fk_next;
    end

    `RHD_ASSERT_IMP(a_drop_silent, adv && drop_reg && !in_ps_reg, !bnd_next.sc && bnd_next.nb == 2'd0 && bnd_next.err == rhd_pkg::ERR_NONE)
    `RHD_ASSERT_IMP(a_sub_rest_left, phase_reg == rhd_pkg::PH_SUB_REST, sub_left_reg != 16'd0)
    `RHD_ASSERT_IMP(a_drop_idle, drop_reg, phase_reg == rhd_pkg::PH_IDLE)

endmodule

`default_nettype wire

>>> sv/rhd_emit.sv
// ----------------------------------------------------------------------------
// rhd_emit
// Result register: holds one bundle, hands out one result per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_emit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 bnd_valid,
    output logic                      bnd_ready,
    input  wire rhd_pkg::rhd_bundle_t bnd,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // out_byte[7:0]
    output logic [5:0]                m_axis_tuser,  // byte_valid[0], nal_begin[1],
                                                     // frame_class[3:2], error_code[5:4]
    output logic                      m_axis_tlast
);

    `include "rtp_h264_hevc_depacketizer_top_assert.svh"

    logic                 valid_reg;
    rhd_pkg::rhd_bundle_t bnd_reg;
    logic [2:0]           idx_reg;

    logic [2:0]           cnt;
    logic                 in_sc;
    logic                 pick_b1;
    logic                 done;
    logic [7:0]           obyte;
    logic                 ovalid;
    logic                 obegin;

    assign cnt = bnd_reg.sc ? (3'd4 + {1'b0, bnd_reg.nb}) :
                 ((bnd_reg.nb == 2'd0) ? 3'd1 : {1'b0, bnd_reg.nb});
    assign in_sc   = bnd_reg.sc && (idx_reg < 3'd4);
    assign pick_b1 = bnd_reg.sc ? (idx_reg == 3'd5) : (idx_reg == 3'd1);

    always_comb
    begin
        if (in_sc)
            obyte = (idx_reg == 3'd3) ? rhd_pkg::SC_ONE : rhd_pkg::SC_ZERO;
        else if (bnd_reg.nb == 2'd0)
            obyte = 8'd0;
        else
            obyte = pick_b1 ? bnd_reg.b1 : bnd_reg.b0;
    end

    assign ovalid        = in_sc || (bnd_reg.nb != 2'd0);
    assign obegin        = bnd_reg.sc && (idx_reg == 3'd0);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = (idx_reg == cnt - 3'd1);
    assign m_axis_tdata  = obyte;
    assign m_axis_tuser  = {bnd_reg.err, bnd_reg.fclass, obegin, ovalid};
    assign done          = valid_reg && m_axis_tready && m_axis_tlast;
    assign bnd_ready     = !valid_reg || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else if (bnd_ready && bnd_valid)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 3'd0;
        end
        else if (done)
            valid_reg <= 1'b0;
        else if (valid_reg && m_axis_tready)
            idx_reg <= idx_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (bnd_ready && bnd_valid)
            bnd_reg <= bnd;
    end

    `RHD_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(idx_reg))
    `RHD_ASSERT_IMP(a_begin_first, m_axis_tvalid && m_axis_tuser[1], idx_reg == 3'd0 && m_axis_tuser[0])
    `RHD_ASSERT_IMP(a_err_alone, m_axis_tvalid && m_axis_tuser[5:4] != rhd_pkg::ERR_NONE, m_axis_tlast && !m_axis_tuser[0])

endmodule

`default_nettype wire

>>> sv/rtp_h264_hevc_depacketizer_top.sv
// ----------------------------------------------------------------------------
// rtp_h264_hevc_depacketizer_top
// RTP H.264 / HEVC payload to Annex-B byte stream converter.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one RTP payload byte per request, with bytes_left and the
//   packet_start / frame_start flags. m_axis gives 1 to 6 results per payload
//   byte: stream bytes, start codes (nal_begin on the first 00), a single
//   error result or an empty one; tlast marks the final result of each byte.
//   cfg_valid/cfg_data writes codec_select (0 H.264, 1 HEVC); write it only
//   while the block is empty. cfg_ready is always high.
// Timing:
//   The input register and the result register form two stages; the result
//   register emits one result per cycle while m_axis_tready is high and holds
//   a byte's bundle until its last result is taken. Plain payload bytes flow
//   at one per cycle while m_axis_tready stays high; a start code adds 4
//   results, so a byte that opens a NAL yields 5 results (6 at an HEVC
//   fragment start, 4 at an aggregate size field).
// Reset / stall:
//   rst_n clears both stages, the parser state (idle, class B) and selects
//   H.264. When m_axis_tready is low the held result stays and s_axis_tready
//   drops once the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_h264_hevc_depacketizer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,       // codec_select
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // data_byte[7:0], bytes_left[23:8]
    input  wire logic [1:0]  s_axis_tuser,   // packet_start[0], frame_start[1]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte[7:0]
    output logic [5:0]       m_axis_tuser,   // byte_valid[0], nal_begin[1],
                                             // frame_class[3:2], error_code[5:4]
    output logic             m_axis_tlast    // last
);

    logic                 bnd_valid;
    logic                 bnd_ready;
    rhd_pkg::rhd_bundle_t bnd;

    rhd_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .bnd_valid     (bnd_valid),
        .bnd_ready     (bnd_ready),
        .bnd           (bnd)
    );

    rhd_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .bnd_valid     (bnd_valid),
        .bnd_ready     (bnd_ready),
        .bnd           (bnd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> sim/annexb_stream_checker.sv
// ----------------------------------------------------------------------------
// annexb_stream_checker
// Watches the config, payload and stream channels of the RTP depacketizer.
// Every accepted payload byte is run through a local Annex-B parser. The
// parser's results are queued, and each result that leaves the block is
// compared with the oldest queued one. Counts failures for the top.
// ----------------------------------------------------------------------------
module annexb_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [5:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       nal_start;
        logic [1:0] fclass;
        logic [1:0] err;
        logic       is_last;
    } stream_result_t;

    stream_result_t annexb_q[$];
    stream_result_t step_q[$];

    // local copy of the parser state
    logic              codec_sel;
    rhd_pkg::phase_t   ph;
    logic [7:0]        hdr_a;
    logic [7:0]        hdr_b;
    logic [7:0]        len_hi;
    logic [15:0]       sub_left;
    logic [1:0]        fkind;
    logic              dropping;
    int                errs = 0;

    function automatic string show(input stream_result_t r);
        return $sformatf("byte=%02h valid=%0d nal=%0d class=%0d err=%0d last=%0d",
                         r.data, r.valid, r.nal_start, r.fclass, r.err, r.is_last);
    endfunction

    function automatic void put(input logic [7:0] b, input logic v, input logic ns,
                                input logic [1:0] e);
        stream_result_t x;
        if (step_q.size() < 6)
        begin
            x = '0;
            x.data = b;
            x.valid = v;
            x.nal_start = ns;
            x.err = e;
            step_q.push_back(x);
        end
    endfunction

    function automatic void put_start_code();
        put(rhd_pkg::SC_ZERO, 1'b1, 1'b1, rhd_pkg::ERR_NONE);
        put(rhd_pkg::SC_ZERO, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
        put(rhd_pkg::SC_ZERO, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
        put(rhd_pkg::SC_ONE, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
    endfunction

    function automatic void abort_packet(input logic [1:0] e);
        put(8'h00, 1'b0, 1'b0, e);
        dropping = 1'b1;
        ph = rhd_pkg::PH_IDLE;
    endfunction

    // H.264: IDR and SEI mark intra; a NAL with nonzero nal_ref_idc lifts B to other
    function automatic void avc_kind(input logic [7:0] h);
        logic [4:0] t;
        t = h[4:0];
        if (t >= 5'd1 && t <= rhd_pkg::H264_T_MAX)
        begin
            if (t == rhd_pkg::H264_T_IDR || t == rhd_pkg::H264_T_SEI)
                fkind = rhd_pkg::FK_INTRA;
            else if (fkind == rhd_pkg::FK_B && h[6:5] != 2'd0)
                fkind = rhd_pkg::FK_OTHER;
        end
    endfunction

    function automatic void hevc_kind(input logic [7:0] h);
        logic [5:0] t;
        t = h[6:1];
        fkind = (t >= rhd_pkg::HEVC_T_IRAP_LO && t <= rhd_pkg::HEVC_T_IRAP_HI) ?
                rhd_pkg::FK_INTRA : rhd_pkg::FK_OTHER;
    endfunction

    // two bytes or fewer cannot hold a size field and a non-empty sub-NAL
    function automatic void next_sub(input int unsigned rem);
        ph = (rem > 2) ? rhd_pkg::PH_SIZE_HI : rhd_pkg::PH_TRAIL;
    endfunction

    function automatic void parse_header(input logic [7:0] b, input int unsigned len);
        logic [4:0] t5;
        logic [5:0] t6;
        t5 = b[4:0];
        t6 = b[6:1];
        hdr_a = b;
        if (codec_sel == rhd_pkg::CODEC_H264)
        begin
            if (t5 >= 5'd1 && t5 <= rhd_pkg::H264_T_MAX)
            begin
                avc_kind(b);
                put_start_code();
                put(b, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
                ph = rhd_pkg::PH_COPY;
            end
            else if (t5 == rhd_pkg::H264_T_STAPA)
                next_sub(len - 1);
            else if (t5 == rhd_pkg::H264_T_FUA)
            begin
                if (len - 1 > 1)
                    ph = rhd_pkg::PH_FU_HDR;
                else
                    abort_packet(rhd_pkg::ERR_FU_SHORT);
            end
            else
                abort_packet(rhd_pkg::ERR_TYPE);
        end
        else
        begin
            hevc_kind(b);
            if (t6 <= rhd_pkg::HEVC_T_MAX)
            begin
                put_start_code();
                put(b, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
                ph = rhd_pkg::PH_COPY;
            end
            else if (t6 == rhd_pkg::HEVC_T_AP)
                ph = rhd_pkg::PH_SKIP;
            else if (t6 == rhd_pkg::HEVC_T_FU)
            begin
                if (len >= 4)
                    ph = rhd_pkg::PH_SECOND;
                else
                    abort_packet(rhd_pkg::ERR_FU_SHORT);
            end
            else
                abort_packet(rhd_pkg::ERR_TYPE);
        end
    endfunction

    function automatic void parse_body(input logic [7:0] b, input int unsigned len);
        logic [7:0]  rebuilt;
        int unsigned sz;
        case (ph)
            rhd_pkg::PH_SKIP:
                next_sub(len - 1);
            rhd_pkg::PH_SECOND:
            begin
                hdr_b = b;
                ph = rhd_pkg::PH_FU_HDR;
            end
            rhd_pkg::PH_FU_HDR:
            begin
                // rebuilt NAL header is sent only on the start fragment
                if (codec_sel == rhd_pkg::CODEC_H264)
                begin
                    rebuilt = {hdr_a[7:5], b[4:0]};
                    if (b[7])
                    begin
                        put_start_code();
                        put(rebuilt, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
                        avc_kind(rebuilt);
                    end
                end
                else
                begin
                    rebuilt = {hdr_a[7], b[5:0], hdr_a[0]};
                    if (b[7])
                    begin
                        put_start_code();
                        put(rebuilt, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
                        put(hdr_b, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
                        hevc_kind(rebuilt);
                    end
                end
                ph = rhd_pkg::PH_COPY;
            end
            rhd_pkg::PH_COPY:
                put(b, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
            rhd_pkg::PH_SIZE_HI:
            begin
                len_hi = b;
                ph = rhd_pkg::PH_SIZE_LO;
            end
            rhd_pkg::PH_SIZE_LO:
            begin
                sz = 32'({len_hi, b});
                if (sz > len - 1)
                    abort_packet(rhd_pkg::ERR_SIZE);
                else
                begin
                    put_start_code();
                    if (sz == 0)
                        next_sub(len - 1);
                    else
                    begin
                        sub_left = sz[15:0];
                        ph = rhd_pkg::PH_SUB_FIRST;
                    end
                end
            end
            rhd_pkg::PH_SUB_FIRST, rhd_pkg::PH_SUB_REST:
            begin
                put(b, 1'b1, 1'b0, rhd_pkg::ERR_NONE);
                if (ph == rhd_pkg::PH_SUB_FIRST)
                begin
                    if (codec_sel == rhd_pkg::CODEC_H264)
                        avc_kind(b);
                    else
                        hevc_kind(b);
                end
                if (sub_left > 0)
                    sub_left = sub_left - 16'd1;
                if (sub_left == 0)
                    next_sub(len - 1);
                else
                    ph = rhd_pkg::PH_SUB_REST;
            end
            default: ;
        endcase
    endfunction

    function automatic void depacketize(input logic [7:0] b, input logic ps, input logic fs,
                                        input logic [15:0] left);
        int unsigned    len;
        int             n;
        stream_result_t x;
        step_q.delete();
        len = (left == 16'd0) ? 1 : 32'(left);
        if (fs)
            fkind = rhd_pkg::FK_B;
        if (ps)
        begin
            dropping = 1'b0;
            ph = rhd_pkg::PH_IDLE;
            parse_header(b, len);
        end
        else if (!dropping && ph != rhd_pkg::PH_IDLE)
            parse_body(b, len);
        if (len == 1)
            ph = rhd_pkg::PH_IDLE;
        if (step_q.size() == 0)
            put(8'h00, 1'b0, 1'b0, rhd_pkg::ERR_NONE);
        n = step_q.size();
        for (int k = 0; k < n; k++)
        begin
            x = step_q[k];
            x.fclass = fkind;
            x.is_last = (k == n - 1);
            annexb_q.push_back(x);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stream_result_t got;
        stream_result_t want;
        if (!rst_n)
        begin
            codec_sel = rhd_pkg::CODEC_H264;
            ph = rhd_pkg::PH_IDLE;
            hdr_a = '0;
            hdr_b = '0;
            len_hi = '0;
            sub_left = '0;
            fkind = rhd_pkg::FK_B;
            dropping = 1'b0;
            annexb_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                codec_sel = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.data = m_axis_tdata;
                got.valid = m_axis_tuser[0];
                got.nal_start = m_axis_tuser[1];
                got.fclass = m_axis_tuser[3:2];
                got.err = m_axis_tuser[5:4];
                got.is_last = m_axis_tlast;
                if (annexb_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result: expected nothing, actual %s",
                             $time, show(got));
                end
                else
                begin
                    want = annexb_q.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        $display("%0t: result mismatch: expected %s", $time, show(want));
                        $display("%0t:                    actual %s", $time, show(got));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                depacketize(s_axis_tdata[7:0], s_axis_tuser[0], s_axis_tuser[1],
                            s_axis_tdata[23:8]);
        end
        fail_count <= errs;
        pending <= annexb_q.size();
    end

endmodule

>>> sim/rtp_h264_hevc_depacketizer_top_tb.sv
// ----------------------------------------------------------------------------
// rtp_h264_hevc_depacketizer_top_tb
// Drives RTP payload packets into the depacketizer for both codecs: a short
// directed set of corner packets, then random single NALs, aggregates,
// fragment runs and malformed traffic, with random stalls on both sides.
// The checker beside the block predicts and compares the stream.
// ----------------------------------------------------------------------------
module rtp_h264_hevc_depacketizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          items_sent = 0;
    int          idle_pct = 15;
    int          stall_pct = 15;
    logic        calm = 1'b0;
    logic        hevc_mode = rhd_pkg::CODEC_H264;
    logic [7:0]  pkt[$];

    rtp_h264_hevc_depacketizer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    annexb_stream_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("rtp_h264_hevc_depacketizer_top_tb: FAIL");
            $finish;
        end
    end

    // stream sink with bursts of back-pressure
    initial
    begin
        int burst;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_codec(input logic sel);
        cfg_valid <= 1'b1;
        cfg_data <= sel;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        hevc_mode = sel;
    endtask

    // one payload byte per request
    task automatic send_item(input logic [7:0] d, input logic ps, input logic fs,
                             input logic [15:0] left);
        int gap;
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {left, d};
        s_axis_tuser <= {fs, ps};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_packet(input logic fs, input logic [15:0] decl);
        for (int i = 0; i < pkt.size(); i++)
            send_item(pkt[i], i == 0, fs && i == 0, decl - 16'(i));
    endtask

    // hold the sender until every stream result is out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endtask

    // NAL header biased toward the types that move the frame class
    function automatic logic [7:0] rand_nal_hdr();
        logic [7:0] h;
        h = 8'($urandom);
        if (hevc_mode == rhd_pkg::CODEC_H264)
        begin
            case ($urandom_range(0, 3))
                0: h[4:0] = rhd_pkg::H264_T_IDR;
                1: h[4:0] = rhd_pkg::H264_T_SEI;
                default: h[4:0] = 5'($urandom_range(1, rhd_pkg::H264_T_MAX));
            endcase
        end
        else if ($urandom_range(0, 1))
            h[6:1] = 6'($urandom_range(rhd_pkg::HEVC_T_IRAP_LO, rhd_pkg::HEVC_T_IRAP_HI));
        else
            h[6:1] = 6'($urandom_range(0, rhd_pkg::HEVC_T_MAX));
        return h;
    endfunction

    task automatic single_nal_packet(input logic fs);
        pkt.delete();
        pkt.push_back(rand_nal_hdr());
        add_random_bytes($urandom_range(0, 6));
        send_packet(fs, 16'(pkt.size()));
    endtask

    task automatic aggregate_packet(input logic fs);
        logic [7:0] h;
        int         sz;
        logic       cut;
        cut = 1'b0;
        pkt.delete();
        h = 8'($urandom);
        if (hevc_mode == rhd_pkg::CODEC_HEVC)
        begin
            h[6:1] = rhd_pkg::HEVC_T_AP;
            pkt.push_back(h);
            pkt.push_back(8'($urandom));
        end
        else
        begin
            h[4:0] = rhd_pkg::H264_T_STAPA;
            pkt.push_back(h);
        end
        repeat ($urandom_range(1, 3))
        begin
            sz = $urandom_range(0, 4);
            pkt.push_back(8'h00);
            pkt.push_back(8'(sz));
            if (sz > 0)
            begin
                pkt.push_back(rand_nal_hdr());
                add_random_bytes(sz - 1);
            end
        end
        case ($urandom_range(0, 7))
            0: add_random_bytes(1);
            1: add_random_bytes(2);
            2:
            begin
                // size runs past the packet end
                pkt.push_back(8'($urandom_range(1, 255)));
                pkt.push_back(8'($urandom));
                add_random_bytes($urandom_range(0, 2));
            end
            3:
            begin
                // long sub-NAL in a packet cut short by the next one
                pkt.push_back(8'($urandom));
                pkt.push_back(8'($urandom));
                add_random_bytes(3);
                cut = 1'b1;
            end
            default: ;
        endcase
        send_packet(fs, cut ? 16'hffff : 16'(pkt.size()));
    endtask

    task automatic fragmented_nal(input logic fs);
        logic [7:0] nal;
        logic [7:0] h;
        logic       s_bit;
        int         nfrag;
        nal = rand_nal_hdr();
        nfrag = $urandom_range(1, 3);
        for (int f = 0; f < nfrag; f++)
        begin
            pkt.delete();
            s_bit = (f == 0) && ($urandom_range(0, 7) != 0);
            if (hevc_mode == rhd_pkg::CODEC_HEVC)
            begin
                h = 8'($urandom);
                h[6:1] = rhd_pkg::HEVC_T_FU;
                pkt.push_back(h);
                pkt.push_back(8'($urandom));
                pkt.push_back({s_bit, f == nfrag - 1, nal[6:1]});
            end
            else
            begin
                pkt.push_back({nal[7:5], rhd_pkg::H264_T_FUA});
                pkt.push_back({s_bit, f == nfrag - 1, 1'b0, nal[4:0]});
            end
            add_random_bytes($urandom_range(1, 5));
            send_packet(fs && f == 0, 16'(pkt.size()));
        end
    endtask

    // stray bytes, random headers, bad lengths, short fragments
    task automatic noise_packet();
        logic [7:0]  h;
        logic [15:0] decl;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
                send_item(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 16'($urandom));
            return;
        end
        pkt.delete();
        h = 8'($urandom);
        case ($urandom_range(0, 2))
            0:
                if (hevc_mode == rhd_pkg::CODEC_HEVC) h[6:1] = rhd_pkg::HEVC_T_FU;
                else h[4:0] = rhd_pkg::H264_T_FUA;
            1:
                if (hevc_mode == rhd_pkg::CODEC_HEVC) h[6:1] = rhd_pkg::HEVC_T_AP;
                else h[4:0] = rhd_pkg::H264_T_STAPA;
            default: ;
        endcase
        pkt.push_back(h);
        add_random_bytes($urandom_range(0, 4));
        case ($urandom_range(0, 3))
            0: decl = 16'd0;
            1: decl = 16'($urandom);
            2: decl = 16'(pkt.size() + $urandom_range(1, 3));
            default: decl = 16'(pkt.size());
        endcase
        for (int i = 0; i < pkt.size(); i++)
            send_item(pkt[i], i == 0, $urandom_range(0, 7) == 0, decl - 16'(i));
    endtask

    task automatic random_traffic(input int target);
        int   stop;
        int   pick;
        logic fs;
        stop = items_sent + target;
        while (items_sent < stop)
        begin
            pick = $urandom_range(0, 19);
            fs = ($urandom_range(0, 3) == 0);
            if (pick < 5)
                single_nal_packet(fs);
            else if (pick < 9)
                aggregate_packet(fs);
            else if (pick < 15)
                fragmented_nal(fs);
            else
                noise_packet();
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    task automatic directed_h264();
        send_item(8'hff, 1'b0, 1'b0, 16'd1);        // stray byte while idle
        pkt = '{{3'b011, rhd_pkg::H264_T_IDR}, 8'h00, 8'hff};
        send_packet(1'b1, 16'd3);
        pkt = '{{3'b011, rhd_pkg::H264_T_FUA}};     // fragment too short
        send_packet(1'b0, 16'd2);
        pkt = '{8'h00};                             // type 0 is not handled
        send_packet(1'b0, 16'd1);
        // empty sub-NAL, one-byte sub-NAL, one-byte tail
        pkt = '{{3'b000, rhd_pkg::H264_T_STAPA}, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'haa};
        send_packet(1'b0, 16'd7);
        pkt = '{{3'b000, rhd_pkg::H264_T_STAPA}, 8'hff, 8'hff};
        send_packet(1'b0, 16'd3);
        // start fragment, abandoned by the next packet
        pkt = '{{3'b011, rhd_pkg::H264_T_FUA}, {3'b100, rhd_pkg::H264_T_IDR}, 8'h11};
        send_packet(1'b1, 16'hffff);
        pkt = '{8'h41};                             // zero length reads as one
        send_packet(1'b0, 16'd0);
    endtask

    task automatic directed_hevc();
        pkt = '{{1'b0, rhd_pkg::HEVC_T_AP, 1'b0}, 8'h01, 8'h00, 8'h02, 8'h40, 8'h01};
        send_packet(1'b1, 16'd6);
        pkt = '{{1'b0, rhd_pkg::HEVC_T_FU, 1'b0}};  // fragment too short
        send_packet(1'b0, 16'd3);
        pkt = '{8'h7e};                             // type 63 is not handled
        send_packet(1'b0, 16'd1);
        pkt = '{{1'b0, rhd_pkg::HEVC_T_FU, 1'b0}, 8'h01, {2'b10, rhd_pkg::HEVC_T_IRAP_HI},
                8'hab};
        send_packet(1'b0, 16'd4);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_codec(rhd_pkg::CODEC_H264);
        directed_h264();
        drain();
        write_codec(rhd_pkg::CODEC_HEVC);
        directed_hevc();

        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_codec(p[0] ? rhd_pkg::CODEC_HEVC : rhd_pkg::CODEC_H264);
            case (p)
                0: begin idle_pct = 20; stall_pct = 25; end
                1: begin idle_pct = 40; stall_pct = 10; end
                2: begin idle_pct = 8;  stall_pct = 40; end
                default: calm = 1'b1;
            endcase
            random_traffic(p == 3 ? 25 : 35);
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("rtp_h264_hevc_depacketizer_top_tb: PASS");
        else
            $display("rtp_h264_hevc_depacketizer_top_tb: FAIL");
        $finish;
    end

endmodule
